[sv/bglc_pkg.sv]
// shared types and constants for the button gesture led controller
// no dependencies; imported by every module of the block
package bglc_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InTdataW = 40;
  localparam int unsigned OutTdataW = 8;

  // register indexes on the configuration port
  typedef enum logic [CfgAddrW-1:0] {
    REG_LONG_PRESS   = 3'd0,
    REG_DOUBLE_PRESS = 3'd1,
    REG_DEBOUNCE     = 3'd2,
    REG_BLINK0_PER   = 3'd3,
    REG_BLINK1_PER   = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] LongPressRst   = 16'd2000;
  localparam logic [15:0] DoublePressRst = 16'd600;
  localparam logic [7:0]  DebounceRst    = 8'd30;
  localparam logic [15:0] Blink0PerRst   = 16'd1000;
  localparam logic [15:0] Blink1PerRst   = 16'd2000;

  localparam logic [7:0] PollsMax = 8'hFF;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] double_press_ms;
    logic [7:0]  debounce_polls;
    logic [15:0] blink0_period_ms;
    logic [15:0] blink1_period_ms;
  } cfg_t;

  // one poll, button 0 in the lowest bit
  typedef struct packed {
    logic [31:0] now_ms;
    logic        button1_level;
    logic        button0_level;
  } in_item_t;

  typedef struct packed {
    logic exit_pulse;
    logic led1_lit;
    logic led0_lit;
  } result_t;

endpackage

[sv/button_gesture_led_controller_core.sv]
// button gesture led controller: input register, gesture logic, result register
// depends on bglc_pkg, bglc_cfg_regs and bglc_gesture
// an accepted poll waits in the input register; the result register loads it once the output can advance
// throughput: one poll per cycle while the sink does not stall, set by the gesture update loop
// the result register and input register are parted so input is taken while a result waits
// reset: asynchronous active low; leds off, buttons seen as released, defaults loaded
module button_gesture_led_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // bit 0 button0_level, bit 1 button1_level, bits 33:2 now_ms, rest zero
  input  logic [bglc_pkg::InTdataW-1:0]  s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // bit 0 led0_lit, bit 1 led1_lit, bit 2 exit_pulse, rest zero
  output logic [bglc_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [bglc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [bglc_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import bglc_pkg::*;

  cfg_t     cfg;
  in_item_t in_item_q;
  result_t  result, out_q;
  logic     in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic     advance, process, take_in;

  assign advance       = !out_valid_q || m_axis_tready;
  assign process       = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take_in)      in_valid_d = 1'b1;
    else if (process) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (process)            out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) in_item_q <= in_item_t'(s_axis_tdata[33:0]);
    if (process) out_q <= result;
  end

  bglc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bglc_gesture u_gesture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (process),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q};

  // a processed poll always shows up as a result
  a_proc_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process |=> m_axis_tvalid)
    else $error("processed poll produced no result");

  // back-pressure only when both stages are full and the sink stalls
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled without a full pipeline");

endmodule

[sv/bglc_cfg_regs.sv]
// configuration register bank of the button gesture led controller
// depends on bglc_pkg
module bglc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bglc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [bglc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output bglc_pkg::cfg_t                cfg_o
);
  import bglc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        REG_LONG_PRESS:   cfg_d.long_press_ms    = cfg_wdata_i;
        REG_DOUBLE_PRESS: cfg_d.double_press_ms  = cfg_wdata_i;
        REG_DEBOUNCE:     cfg_d.debounce_polls   = cfg_wdata_i[7:0];
        REG_BLINK0_PER:   cfg_d.blink0_period_ms = cfg_wdata_i;
        REG_BLINK1_PER:   cfg_d.blink1_period_ms = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms    <= LongPressRst;
      cfg_q.double_press_ms  <= DoublePressRst;
      cfg_q.debounce_polls   <= DebounceRst;
      cfg_q.blink0_period_ms <= Blink0PerRst;
      cfg_q.blink1_period_ms <= Blink1PerRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  // writes to unused indexes leave every register alone
  a_unused_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_addr_i > REG_BLINK1_PER) |=> $stable(cfg_q))
    else $error("write to unused index changed configuration");

endmodule

[sv/bglc_gesture.sv]
// gesture state and per-poll update logic
// depends on bglc_pkg; state advances on each processed poll
module bglc_gesture (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  bglc_pkg::in_item_t item_i,
  input  bglc_pkg::cfg_t     cfg_i,
  output bglc_pkg::result_t  result_o
);
  import bglc_pkg::*;

  logic        prev0_q, prev0_d, prev1_q, prev1_d;
  logic [31:0] press0_q, press0_d, press1_q, press1_d, click1_q, click1_d;
  logic [31:0] bstart0_q, bstart0_d, bstart1_q, bstart1_d;
  logic [7:0]  polls_q, polls_d;
  logic        blink0_q, blink0_d, blink1_q, blink1_d;
  logic        lit0_q, lit0_d, lit1_q, lit1_d;
  logic        exit_d;

  logic        b0, b1, fall0, rise0, fall1, rise1;
  logic [31:0] now, d0, d1, dc1, lp32;

  // actions run in the order of a poll; the counter may clear mid-way
  always_comb begin
    b0   = item_i.button0_level;
    b1   = item_i.button1_level;
    now  = item_i.now_ms;
    lp32 = {16'd0, cfg_i.long_press_ms};
    fall0 = prev0_q & ~b0;
    rise0 = ~prev0_q & b0;
    fall1 = prev1_q & ~b1;
    rise1 = ~prev1_q & b1;

    press0_d  = press0_q;
    press1_d  = press1_q;
    click1_d  = click1_q;
    bstart0_d = bstart0_q;
    bstart1_d = bstart1_q;
    polls_d   = polls_q;
    blink0_d  = blink0_q;
    blink1_d  = blink1_q;
    lit0_d    = lit0_q;
    lit1_d    = lit1_q;
    exit_d    = 1'b0;

    // button 0
    if (fall0) press0_d = now;
    d0 = now - press0_d;
    if (!b0 && (d0 > lp32) && !blink0_d && (polls_d >= cfg_i.debounce_polls)) begin
      blink0_d  = 1'b1;
      bstart0_d = now;
      polls_d   = '0;
    end
    if (rise0 && (polls_d >= cfg_i.debounce_polls) && (d0 < lp32)) begin
      lit0_d   = ~lit0_d;
      blink0_d = 1'b0;
      polls_d  = '0;
    end
    if (blink0_d && ((now - bstart0_d) >= {16'd0, cfg_i.blink0_period_ms})) begin
      lit0_d    = ~lit0_d;
      bstart0_d = now;
    end

    // button 1, double press skips the counter
    dc1 = now - click1_q;
    if (fall1) begin
      if (dc1 < {16'd0, cfg_i.double_press_ms}) begin
        blink1_d  = ~blink1_d;
        click1_d  = '0;
        bstart1_d = now;
      end else begin
        click1_d = now;
      end
      press1_d = now;
    end
    d1 = now - press1_d;
    if (rise1 && (polls_d >= cfg_i.debounce_polls) && (d1 < lp32)) begin
      blink1_d = 1'b0;
      lit1_d   = ~lit1_d;
      polls_d  = '0;
    end
    if (blink1_d && ((now - bstart1_d) >= {16'd0, cfg_i.blink1_period_ms})) begin
      lit1_d    = ~lit1_d;
      bstart1_d = now;
    end

    if (fall0 && fall1 && (polls_d >= cfg_i.debounce_polls)) begin
      polls_d = '0;
      exit_d  = 1'b1;
    end

    prev0_d = b0;
    prev1_d = b1;
    if (polls_d != PollsMax) polls_d = polls_d + 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev0_q   <= 1'b1;
      prev1_q   <= 1'b1;
      press0_q  <= '0;
      press1_q  <= '0;
      click1_q  <= '0;
      bstart0_q <= '0;
      bstart1_q <= '0;
      polls_q   <= '0;
      blink0_q  <= 1'b0;
      blink1_q  <= 1'b0;
      lit0_q    <= 1'b0;
      lit1_q    <= 1'b0;
    end else if (step_en_i) begin
      prev0_q   <= prev0_d;
      prev1_q   <= prev1_d;
      press0_q  <= press0_d;
      press1_q  <= press1_d;
      click1_q  <= click1_d;
      bstart0_q <= bstart0_d;
      bstart1_q <= bstart1_d;
      polls_q   <= polls_d;
      blink0_q  <= blink0_d;
      blink1_q  <= blink1_d;
      lit0_q    <= lit0_d;
      lit1_q    <= lit1_d;
    end
  end

  assign result_o.led0_lit   = lit0_d;
  assign result_o.led1_lit   = lit1_d;
  assign result_o.exit_pulse = exit_d;

  // an exit clears the counter, which then counts this poll
  a_exit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && exit_d |=> polls_q == 8'd1)
    else $error("poll counter not restarted after exit");

  // state only moves on a processed poll
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> $stable(polls_q) && $stable(lit0_q) && $stable(lit1_q))
    else $error("gesture state changed without a poll");

endmodule

[tb/sv/tb_button_gesture_led_controller_core.sv]
// self-checking testbench for button_gesture_led_controller_core: streams button polls,
// predicts led and exit results in a scoreboard class and checks every output transaction
// depends on bglc_pkg and the core rtl only
module tb_button_gesture_led_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bglc_pkg::*;

  localparam int unsigned NumRegs    = int'(REG_BLINK1_PER) + 1;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;

  // gesture state tracker and queue of led/exit results still owed by the core
  class gesture_scoreboard;
    logic [15:0] long_press_ms;
    logic [15:0] double_press_ms;
    logic [7:0]  debounce_polls;
    logic [15:0] blink0_period_ms;
    logic [15:0] blink1_period_ms;

    bit          prev0, prev1;
    bit [31:0]   press0_t, press1_t, click1_t, blink0_t, blink1_t;
    bit [7:0]    polls;
    bit          blinking0, blinking1, lit0, lit1;

    result_t     led_results_q[$];
    int          errors;

    function new();
      long_press_ms    = LongPressRst;
      double_press_ms  = DoublePressRst;
      debounce_polls   = DebounceRst;
      blink0_period_ms = Blink0PerRst;
      blink1_period_ms = Blink1PerRst;
      prev0     = 1'b1;
      prev1     = 1'b1;
      press0_t  = '0;
      press1_t  = '0;
      click1_t  = '0;
      blink0_t  = '0;
      blink1_t  = '0;
      polls     = '0;
      blinking0 = 1'b0;
      blinking1 = 1'b0;
      lit0      = 1'b0;
      lit1      = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_LONG_PRESS:   long_press_ms    = val;
        REG_DOUBLE_PRESS: double_press_ms  = val;
        REG_DEBOUNCE:     debounce_polls   = val[7:0];
        REG_BLINK0_PER:   blink0_period_ms = val;
        REG_BLINK1_PER:   blink1_period_ms = val;
        default: ;
      endcase
    endfunction

    function void note_poll(in_item_t p);
      bit        b0, b1, fall0, rise0, fall1, rise1;
      bit [31:0] now;
      result_t   r;
      b0    = p.button0_level;
      b1    = p.button1_level;
      now   = p.now_ms;
      fall0 = prev0 && !b0;
      rise0 = !prev0 && b0;
      fall1 = prev1 && !b1;
      rise1 = !prev1 && b1;
      r.exit_pulse = 1'b0;

      if (fall0) press0_t = now;
      if (!b0 && (now - press0_t) > long_press_ms && !blinking0 &&
          polls >= debounce_polls) begin
        blinking0 = 1'b1;
        blink0_t  = now;
        polls     = '0;
      end
      if (rise0 && polls >= debounce_polls && (now - press0_t) < long_press_ms) begin
        lit0      = ~lit0;
        blinking0 = 1'b0;
        polls     = '0;
      end
      if (blinking0 && (now - blink0_t) >= blink0_period_ms) begin
        lit0     = ~lit0;
        blink0_t = now;
      end

      // double press ignores the debounce counter and rearms from time zero
      if (fall1) begin
        if ((now - click1_t) < double_press_ms) begin
          blinking1 = ~blinking1;
          click1_t  = '0;
          blink1_t  = now;
        end else begin
          click1_t = now;
        end
        press1_t = now;
      end
      if (rise1 && polls >= debounce_polls && (now - press1_t) < long_press_ms) begin
        blinking1 = 1'b0;
        lit1      = ~lit1;
        polls     = '0;
      end
      if (blinking1 && (now - blink1_t) >= blink1_period_ms) begin
        lit1     = ~lit1;
        blink1_t = now;
      end

      if (fall0 && fall1 && polls >= debounce_polls) begin
        polls        = '0;
        r.exit_pulse = 1'b1;
      end

      prev0 = b0;
      prev1 = b1;
      if (polls != PollsMax) polls++;

      r.led0_lit = lit0;
      r.led1_lit = lit1;
      led_results_q.push_back(r);
    endfunction

    function void check_result(logic [OutTdataW-1:0] tdata);
      result_t got, want;
      got = result_t'(tdata[2:0]);
      if (led_results_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, actual led0 %0b led1 %0b exit %0b",
                 $time, got.led0_lit, got.led1_lit, got.exit_pulse);
        return;
      end
      want = led_results_q.pop_front();
      if (got.led0_lit !== want.led0_lit || got.led1_lit !== want.led1_lit ||
          got.exit_pulse !== want.exit_pulse) begin
        errors++;
        $display("%0t: mismatch led0/led1/exit, expected %0b %0b %0b, actual %0b %0b %0b",
                 $time, want.led0_lit, want.led1_lit, want.exit_pulse,
                 got.led0_lit, got.led1_lit, got.exit_pulse);
      end
    endfunction

    function int outstanding();
      return led_results_q.size();
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic [InTdataW-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OutTdataW-1:0]  m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0]   cfg_addr_i    = '0;
  logic [CfgDataW-1:0]   cfg_wdata_i   = '0;

  gesture_scoreboard sb = new();

  int unsigned cycles         = 0;
  int unsigned polls_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic [31:0] cur_ms         = '0;

  button_gesture_led_controller_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly steps on the scale of the current long-press limit, now and then a wild jump
  function automatic logic [31:0] rand_dt(logic [31:0] scale);
    case ($urandom_range(0, 19))
      0:       return $urandom;
      1, 2:    return $urandom_range(0, scale * 3 + 2);
      default: return $urandom_range(0, scale / 4 + 3);
    endcase
  endfunction

  task automatic send_poll(bit b0, bit b1, logic [31:0] now);
    in_item_t item;
    item.button0_level = b0;
    item.button1_level = b1;
    item.now_ms        = now;
    cur_ms             = now;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= InTdataW'(item);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_poll(item);
    polls_sent++;
  endtask

  task automatic hold(bit b0, bit b1, int n, logic [31:0] dt_max);
    repeat (n) send_poll(b0, b1, cur_ms + $urandom_range(0, dt_max));
  endtask

  // called right after the last input transaction has been accepted
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_one(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(logic [15:0] lp, logic [15:0] dp, logic [15:0] db,
                            logic [15:0] b0p, logic [15:0] b1p);
    wait_drained();
    write_one(REG_LONG_PRESS, lp);
    write_one(REG_DOUBLE_PRESS, dp);
    write_one(REG_DEBOUNCE, db);
    write_one(REG_BLINK0_PER, b0p);
    write_one(REG_BLINK1_PER, b1p);
    // indexes past the last register must leave everything alone
    for (int i = NumRegs; i < 2 ** CfgAddrW; i++)
      write_one(CfgAddrW'(i), CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_gestures(int unsigned n, int unsigned send_pct, int unsigned recv_pct);
    int unsigned stop_at;
    logic [31:0] lp, dp;
    stop_at = polls_sent + n;
    while (polls_sent < stop_at) begin
      lp = 32'(sb.long_press_ms);
      dp = 32'(sb.double_press_ms);
      send_idle_pct  = ($urandom_range(0, 7) == 0) ? 0 : send_pct;
      recv_stall_pct = ($urandom_range(0, 7) == 0) ? 0 : recv_pct;
      case ($urandom_range(0, 9))
        0: hold(1, 1, $urandom_range(1, 5), rand_dt(lp));
        1: begin
          hold(0, 1, $urandom_range(1, 3), lp / 4 + 1);
          hold(1, 1, 1, lp / 4 + 1);
        end
        2: begin
          hold(0, 1, $urandom_range(2, 6), lp / 2 + 20);
          hold(1, 1, 1, 8);
        end
        3: begin
          hold(1, 0, $urandom_range(1, 3), lp / 4 + 1);
          hold(1, 1, 1, lp / 4 + 1);
        end
        4: begin
          hold(1, 0, 1, dp + 10);
          hold(1, 1, 1, dp / 4 + 1);
          hold(1, 0, 1, dp / 4 + 1);
          hold(1, 1, 1, dp / 4 + 1);
        end
        5: begin
          hold(0, 0, $urandom_range(1, 3), lp / 4 + 1);
          hold(1, 1, 1, lp / 4 + 1);
        end
        6: begin
          hold(1, 0, $urandom_range(2, 6), lp / 2 + 20);
          hold(1, 1, 1, 8);
        end
        7: begin
          hold(0, 1, 1, lp / 4 + 1);
          hold(0, 0, 1, lp / 4 + 1);
          hold(1, 0, 1, lp / 4 + 1);
          hold(1, 1, 1, lp / 4 + 1);
        end
        8: repeat ($urandom_range(1, 4))
             hold(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1, rand_dt(lp));
        default: begin
          // land just short of the 32-bit wrap
          cur_ms = 32'hFFFF_FFFF - $urandom_range(0, lp + 16);
          hold(1, 1, 1, 0);
        end
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: counter still below debounce, so both pressed gives no exit
    send_poll(1, 1, 32'd0);
    send_poll(0, 0, 32'hFFFF_FFFF);
    send_poll(1, 1, 32'd5);

    set_config(16'd100, 16'd50, 16'd0, 16'd0, 16'd3);
    send_poll(1, 1, 32'd0);
    send_poll(0, 1, 32'd10);
    send_poll(1, 1, 32'd20);
    // long press, then zero blink period toggles on every poll
    send_poll(0, 1, 32'd30);
    send_poll(0, 1, 32'd200);
    send_poll(0, 1, 32'd201);
    send_poll(1, 1, 32'd202);
    send_poll(0, 1, 32'd210);
    send_poll(1, 1, 32'd215);
    send_poll(1, 0, 32'd300);
    send_poll(1, 1, 32'd310);
    send_poll(1, 0, 32'd400);
    send_poll(1, 1, 32'd405);
    send_poll(1, 0, 32'd420);
    send_poll(1, 1, 32'd425);
    send_poll(1, 1, 32'd430);
    // third press close to time zero counts as a double press again
    send_poll(1, 0, 32'd10);
    send_poll(1, 1, 32'd12);
    send_poll(0, 0, 32'd500);
    send_poll(1, 1, 32'd510);
    send_poll(1, 1, 32'hFFFF_FFFF);
    send_poll(0, 1, 32'hFFFF_FFFA);

    set_config(LongPressRst, DoublePressRst, 16'd2, Blink0PerRst, Blink1PerRst);
    run_gestures(60, 0, 0);

    // zero limits; debounce written with junk in the upper byte
    set_config(16'd0, 16'd0, 16'hA505, 16'd1, 16'hFFFF);
    run_gestures(60, 49, 0);

    // top values; a long quiet stretch drives the poll counter into saturation
    set_config(16'hFFFF, 16'hFFFF, 16'd255, 16'hFFFF, 16'd1);
    recv_stall_pct = 49;
    hold(1, 1, 258, 32'd50);
    run_gestures(30, 0, 49);

    set_config(16'd50, 16'd200, 16'd1, 16'd7, 16'd0);
    run_gestures(60, 14, 14);

    wait_drained();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
